@@ rtl/display_sleep_backlight_fade_unit_assert.svh @@
// Assertion helpers used by dsbf_core.
// Both forms sample on clk and are switched off while arst_n is low.
`ifndef DISPLAY_SLEEP_BACKLIGHT_FADE_UNIT_ASSERT_SVH
`define DISPLAY_SLEEP_BACKLIGHT_FADE_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DSBF_ASSERT_NOW(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dsbf assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define DSBF_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dsbf assertion failed");

`endif

@@ rtl/dsbf_pkg.sv @@
package dsbf_pkg;

	// Field widths.
	localparam int unsigned CMD_W     = 2;
	localparam int unsigned INACT_W   = 32;
	localparam int unsigned TIME_W    = 63;
	localparam int unsigned LEVEL_W   = 7;
	localparam int unsigned INC_W     = 4;
	localparam int unsigned TIMEOUT_W = 26;
	localparam int unsigned GRACE_W   = 26;
	localparam int unsigned THRESH_W  = 16;
	localparam int unsigned PADDR_W   = 4;
	localparam int unsigned PDATA_W   = 32;

	// Register reset values and timeout clamp limits.
	localparam logic [TIMEOUT_W-1:0] TIMEOUT_DEFAULT = TIMEOUT_W'(3 * 60 * 1000);
	localparam logic [TIMEOUT_W-1:0] TIMEOUT_MIN     = TIMEOUT_W'(1 * 60 * 1000);
	localparam logic [TIMEOUT_W-1:0] TIMEOUT_MAX     = TIMEOUT_W'(12 * 60 * 60 * 1000);
	localparam logic [GRACE_W-1:0]   GRACE_DEFAULT   = GRACE_W'(1000 * 1000);
	localparam logic [THRESH_W-1:0]  THRESH_DEFAULT  = THRESH_W'(500);

	// Backlight levels and fade ramp.
	localparam logic [LEVEL_W-1:0] LEVEL_FULL = LEVEL_W'(100);
	localparam int unsigned RAMP_STEPS = 8;
	localparam int unsigned RAMP_SHIFT = $clog2(RAMP_STEPS);

	// Register indexes on the configuration port.
	localparam logic [1:0] REG_TIMEOUT = 2'd0;
	localparam logic [1:0] REG_GRACE   = 2'd1;
	localparam logic [1:0] REG_THRESH  = 2'd2;

	// Event codes.
	typedef enum logic [CMD_W-1:0] {
		CMD_CHECK = 2'd0,
		CMD_TICK  = 2'd1,
		CMD_WAKE  = 2'd2,
		CMD_SLEEP = 2'd3
	} cmd_t;

	// Register values as seen by the event logic.
	typedef struct packed {
		logic [TIMEOUT_W-1:0] sleep_after_ms;
		logic [GRACE_W-1:0]   grace_us;
		logic [THRESH_W-1:0]  thresh_ms;
	} cfg_t;

endpackage

@@ rtl/dsbf_evt_if.sv @@
interface dsbf_evt_if;
	import dsbf_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [CMD_W-1:0]     cmd;
	logic [INACT_W-1:0]   idle_ms;
	logic                 booking_active;
	logic [TIME_W-1:0]    now_us;

	modport source (output valid, cmd, idle_ms, booking_active, now_us, input ready);
	modport sink (input valid, cmd, idle_ms, booking_active, now_us, output ready);
endinterface

@@ rtl/dsbf_res_if.sv @@
interface dsbf_res_if;
	import dsbf_pkg::*;

	logic                 valid;
	logic                 ready;
	logic                 drive_valid;
	logic [LEVEL_W-1:0]   brightness;
	logic                 sleeping;
	logic                 fade_active;

	modport source (output valid, drive_valid, brightness, sleeping, fade_active, input ready);
	modport sink (input valid, drive_valid, brightness, sleeping, fade_active, output ready);
endinterface

@@ rtl/dsbf_cfg.sv @@
module dsbf_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [dsbf_pkg::PADDR_W-1:0]  paddr,
	input  logic [dsbf_pkg::PDATA_W-1:0]  pwdata,
	output logic [dsbf_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready,
	output dsbf_pkg::cfg_t                cfg
);
	import dsbf_pkg::*;

	logic [TIMEOUT_W-1:0] timeout_q;
	logic [GRACE_W-1:0]   grace_q;
	logic [THRESH_W-1:0]  thresh_q;
	logic [TIMEOUT_W-1:0] timeout_wr;
	logic [1:0]           reg_idx;
	logic                 wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[PADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite;

	// A nonzero timeout is clamped into the allowed window.
	always_comb begin
		timeout_wr = pwdata[TIMEOUT_W-1:0];
		if (timeout_wr != '0 && timeout_wr < TIMEOUT_MIN) begin
			timeout_wr = TIMEOUT_MIN;
		end
		if (timeout_wr > TIMEOUT_MAX) begin
			timeout_wr = TIMEOUT_MAX;
		end
	end

	// Register writes; addresses past the last register are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_DEFAULT;
			grace_q   <= GRACE_DEFAULT;
			thresh_q  <= THRESH_DEFAULT;
		end else if (wr_en) begin
			case (reg_idx)
				REG_TIMEOUT: timeout_q <= timeout_wr;
				REG_GRACE:   grace_q   <= pwdata[GRACE_W-1:0];
				REG_THRESH:  thresh_q  <= pwdata[THRESH_W-1:0];
				default: ;
			endcase
		end
	end

	// Read back.
	always_comb begin
		case (reg_idx)
			REG_TIMEOUT: prdata = PDATA_W'(timeout_q);
			REG_GRACE:   prdata = PDATA_W'(grace_q);
			REG_THRESH:  prdata = PDATA_W'(thresh_q);
			default:     prdata = '0;
		endcase
	end

	assign cfg.sleep_after_ms = timeout_q;
	assign cfg.grace_us       = grace_q;
	assign cfg.thresh_ms      = thresh_q;

endmodule

@@ rtl/dsbf_core.sv @@
module dsbf_core (
	input  logic           clk,
	input  logic           arst_n,
	input  dsbf_pkg::cfg_t cfg,
	dsbf_evt_if.sink       evt,
	dsbf_res_if.source     res
);
	import dsbf_pkg::*;

	// Input stage.
	logic                 valid_s1;
	cmd_t                 cmd_s1;
	logic [INACT_W-1:0]   inact_s1;
	logic                 booking_s1;
	logic [TIME_W-1:0]    now_s1;

	// Result stage.
	logic                 valid_s2;
	logic                 drive_s2;
	logic [LEVEL_W-1:0]   level_s2;
	logic                 sleeping_s2;
	logic                 fade_s2;

	// Controller state.
	logic                 asleep_q;
	logic [TIME_W-1:0]    entry_q;
	logic [LEVEL_W-1:0]   last_level_q;
	logic [LEVEL_W-1:0]   ramp_target_q;
	logic [INC_W-1:0]     ramp_inc_q;
	logic [LEVEL_W-1:0]   ramp_level_q;
	logic                 ramp_run_q;

	// Next-state values.
	logic                 asleep_d;
	logic [TIME_W-1:0]    entry_d;
	logic [LEVEL_W-1:0]   last_level_d;
	logic [LEVEL_W-1:0]   ramp_target_d;
	logic [INC_W-1:0]     ramp_inc_d;
	logic [LEVEL_W-1:0]   ramp_level_d;
	logic                 ramp_run_d;
	logic                 drive_d;
	logic [LEVEL_W-1:0]   level_d;

	logic                 do_sleep;
	logic                 do_wake;
	logic                 grace_over;
	logic [TIME_W-1:0]    elapsed;
	logic [LEVEL_W-1:0]   ramp_sum;
	logic [LEVEL_W-1:0]   inc_sum;
	logic                 advance;

	// The result register frees up when it is empty or being taken.
	assign advance   = !valid_s2 || res.ready;
	assign evt.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (evt.valid && evt.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (evt.valid && evt.ready) begin
			cmd_s1     <= cmd_t'(evt.cmd);
			inact_s1   <= evt.idle_ms;
			booking_s1 <= evt.booking_active;
			now_s1     <= evt.now_us;
		end
	end

	// Grace time has passed only when time has moved forward past it.
	assign elapsed    = now_s1 - entry_q;
	assign grace_over = (now_s1 > entry_q) && (elapsed > TIME_W'(cfg.grace_us));
	assign ramp_sum   = ramp_level_q + LEVEL_W'(ramp_inc_q);
	assign inc_sum    = last_level_q + LEVEL_W'(RAMP_STEPS - 1);

	// Event decode and state update for the word in the input stage.
	always_comb begin
		asleep_d      = asleep_q;
		entry_d       = entry_q;
		last_level_d  = last_level_q;
		ramp_target_d = ramp_target_q;
		ramp_inc_d    = ramp_inc_q;
		ramp_level_d  = ramp_level_q;
		ramp_run_d    = ramp_run_q;
		drive_d       = 1'b0;
		level_d       = '0;
		do_sleep      = 1'b0;
		do_wake       = 1'b0;

		case (cmd_s1)
			CMD_CHECK: begin
				if (cfg.sleep_after_ms != '0) begin
					if (booking_s1) begin
						do_wake = asleep_q;
					end else if (!asleep_q && inact_s1 >= INACT_W'(cfg.sleep_after_ms)) begin
						do_sleep = 1'b1;
					end else if (asleep_q && inact_s1 <= INACT_W'(cfg.thresh_ms)) begin
						do_wake = grace_over;
					end
				end
			end
			CMD_TICK: begin
				if (ramp_run_q) begin
					ramp_level_d = ramp_sum;
					drive_d      = 1'b1;
					if (ramp_sum >= ramp_target_q) begin
						ramp_run_d = 1'b0;
						level_d    = ramp_target_q;
					end else begin
						level_d = ramp_sum;
					end
				end
			end
			CMD_WAKE: begin
				do_wake = 1'b1;
			end
			CMD_SLEEP: begin
				do_sleep = 1'b1;
			end
			default: ;
		endcase

		// Entering sleep blanks the backlight once.
		if (do_sleep && !asleep_q) begin
			asleep_d = 1'b1;
			entry_d  = now_s1;
			drive_d  = 1'b1;
			level_d  = '0;
		end

		// Waking from sleep starts the fade; when awake, restore the last level.
		if (do_wake) begin
			drive_d = 1'b1;
			if (!asleep_q) begin
				level_d = last_level_q;
			end else begin
				asleep_d      = 1'b0;
				entry_d       = '0;
				ramp_target_d = last_level_q;
				ramp_level_d  = '0;
				ramp_inc_d    = inc_sum[LEVEL_W-1:RAMP_SHIFT];
				ramp_run_d    = 1'b1;
				level_d       = '0;
			end
		end

		// Any nonzero driven level is remembered for the next wake.
		if (level_d > LEVEL_FULL) begin
			level_d = LEVEL_FULL;
		end
		if (drive_d && level_d != '0) begin
			last_level_d = level_d;
		end
	end

	// State and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2      <= 1'b0;
			asleep_q      <= 1'b0;
			entry_q       <= '0;
			last_level_q  <= LEVEL_FULL;
			ramp_target_q <= '0;
			ramp_inc_q    <= '0;
			ramp_level_q  <= '0;
			ramp_run_q    <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				asleep_q      <= asleep_d;
				entry_q       <= entry_d;
				last_level_q  <= last_level_d;
				ramp_target_q <= ramp_target_d;
				ramp_inc_q    <= ramp_inc_d;
				ramp_level_q  <= ramp_level_d;
				ramp_run_q    <= ramp_run_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			drive_s2    <= drive_d;
			level_s2    <= level_d;
			sleeping_s2 <= asleep_d;
			fade_s2     <= ramp_run_d;
		end
	end

	assign res.valid       = valid_s2;
	assign res.drive_valid = drive_s2;
	assign res.brightness  = level_s2;
	assign res.sleeping    = sleeping_s2;
	assign res.fade_active = fade_s2;

`include "display_sleep_backlight_fade_unit_assert.svh"

	// The remembered level is always a real, in-range brightness.
	`DSBF_ASSERT_NOW(a_last_level_range, 1'b1, last_level_q != '0 && last_level_q <= LEVEL_FULL)
	// A running fade has not reached its target yet.
	`DSBF_ASSERT_NOW(a_ramp_below_target, ramp_run_q, ramp_level_q < ramp_target_q)
	// An undriven result carries zero brightness.
	`DSBF_ASSERT_NOW(a_idle_level_zero, valid_s2 && !drive_s2, level_s2 == '0)
	// A word moving out of the input stage shows up as a result.
	`DSBF_ASSERT_NEXT(a_stage_moves, valid_s1 && advance, valid_s2)

endmodule

@@ rtl/display_sleep_backlight_fade_unit.sv @@
// Display sleep controller with backlight fade-in.
// The evt channel takes one event word per cycle while ready is high: a
// periodic check (with inactivity time, booking flag and current time), a
// fade tick, a wake request or a sleep request. The res channel returns
// exactly one word per event: whether the backlight is driven, the
// brightness in percent, and the sleep and fade flags after the event.
// Three registers on the APB port set the sleep timeout (clamped on write),
// the wake grace time and the activity threshold; write them only while idle.
// An accepted event is registered in the input register, and its result is
// registered in the result register. Throughput is one event per cycle when
// the receiver does not stall, set by the single compare-and-add stage between
// the input and result registers that also updates the controller state.
// When the receiver stalls, the result register holds its word and the input
// register still takes one more event; further events then wait on ready.
// Reset wakes the display, stops any fade, sets the remembered level to full
// brightness and loads the register defaults.
module display_sleep_backlight_fade_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [dsbf_pkg::PADDR_W-1:0]  paddr,
	input  logic [dsbf_pkg::PDATA_W-1:0]  pwdata,
	output logic [dsbf_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready,
	dsbf_evt_if.sink                      evt,
	dsbf_res_if.source                    res
);
	import dsbf_pkg::*;

	cfg_t cfg;

	// Configuration registers.
	dsbf_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Event pipeline and controller state.
	dsbf_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.evt    (evt),
		.res    (res)
	);

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps

module tb;
	import dsbf_pkg::*;

	localparam int unsigned QUIET_LIMIT = 1000;
	localparam int unsigned DRAIN_CYCLES = 4;
	localparam int unsigned WORDS_PER_SETTING = 55;

	// One word on the result channel, as predicted or as seen.
	typedef struct packed {
		logic               drive_valid;
		logic [LEVEL_W-1:0] brightness;
		logic               sleeping;
		logic               fade_active;
	} backlight_word_t;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	dsbf_evt_if evt_ch ();
	dsbf_res_if res_ch ();

	display_sleep_backlight_fade_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.evt     (evt_ch.sink),
		.res     (res_ch.source)
	);

	// Register copies held by the predictor.
	logic [TIMEOUT_W-1:0] sleep_after_cfg = TIMEOUT_DEFAULT;
	logic [GRACE_W-1:0]   grace_us_cfg   = GRACE_DEFAULT;
	logic [THRESH_W-1:0]  thresh_ms_cfg  = THRESH_DEFAULT;

	// Controller state held by the predictor.
	logic               dark             = 1'b0;
	logic [TIME_W-1:0]  sleep_stamp_us   = '0;
	logic [LEVEL_W-1:0] remembered_level = LEVEL_FULL;
	logic [LEVEL_W-1:0] fade_target      = '0;
	logic [INC_W-1:0]   fade_step        = '0;
	logic [LEVEL_W-1:0] fade_level       = '0;
	logic               fade_running     = 1'b0;

	// Backlight drive produced by the event being predicted.
	logic               drive_now;
	logic [LEVEL_W-1:0] drive_lvl;

	backlight_word_t pending_backlight[$];

	int unsigned fail_count    = 0;
	int unsigned events_sent   = 0;
	int unsigned words_checked = 0;
	int unsigned settings_used = 0;
	int unsigned quiet_cycles  = 0;
	int unsigned send_idle_pct = 23;
	int unsigned recv_idle_pct = 80;
	logic [TIME_W-1:0] clock_us = '0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic void check_field(string field, logic [63:0] want, logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", field, want, got);
			fail_count++;
		end
	endfunction

	// Drive a level to the backlight; any nonzero level is remembered.
	function automatic void drive_backlight(logic [LEVEL_W-1:0] lvl);
		logic [LEVEL_W-1:0] clipped;
		clipped = (lvl > LEVEL_FULL) ? LEVEL_FULL : lvl;
		if (clipped != '0) begin
			remembered_level = clipped;
		end
		drive_now = 1'b1;
		drive_lvl = clipped;
	endfunction

	function automatic void enter_dark(logic [TIME_W-1:0] now);
		if (!dark) begin
			dark = 1'b1;
			sleep_stamp_us = now;
			drive_backlight('0);
		end
	endfunction

	// Leaving sleep starts the fade from zero; when awake, the remembered level is driven.
	function automatic void wake_display();
		if (!dark) begin
			drive_backlight(remembered_level);
		end else begin
			dark = 1'b0;
			sleep_stamp_us = '0;
			fade_target = remembered_level;
			fade_level = '0;
			fade_step = INC_W'((int'(remembered_level) + RAMP_STEPS - 1) / RAMP_STEPS);
			fade_running = 1'b1;
			drive_backlight('0);
		end
	endfunction

	function automatic backlight_word_t predict_backlight(cmd_t c, logic [INACT_W-1:0] inact,
			logic booking, logic [TIME_W-1:0] now);
		backlight_word_t word;
		drive_now = 1'b0;
		drive_lvl = '0;
		case (c)
			CMD_CHECK: begin
				if (sleep_after_cfg != '0) begin
					if (booking) begin
						if (dark) begin
							wake_display();
						end
					end else if (!dark && inact >= INACT_W'(sleep_after_cfg)) begin
						enter_dark(now);
					end else if (dark && inact <= INACT_W'(thresh_ms_cfg)) begin
						// Time that has gone backward never counts as grace passed.
						if (now > sleep_stamp_us &&
								(now - sleep_stamp_us) > TIME_W'(grace_us_cfg)) begin
							wake_display();
						end
					end
				end
			end
			CMD_TICK: begin
				if (fade_running) begin
					fade_level = fade_level + LEVEL_W'(fade_step);
					if (fade_level >= fade_target) begin
						fade_running = 1'b0;
						drive_backlight(fade_target);
					end else begin
						drive_backlight(fade_level);
					end
				end
			end
			CMD_WAKE: begin
				wake_display();
			end
			default: begin
				enter_dark(now);
			end
		endcase
		word.drive_valid = drive_now;
		word.brightness = drive_now ? drive_lvl : '0;
		word.sleeping = dark;
		word.fade_active = fade_running;
		return word;
	endfunction

	// Predict each accepted event word and check each accepted result word.
	always @(posedge clk) begin : monitor
		backlight_word_t want;
		logic evt_acc;
		logic res_acc;
		evt_acc = arst_n && evt_ch.valid && evt_ch.ready;
		res_acc = arst_n && res_ch.valid && res_ch.ready;
		if (evt_acc) begin
			pending_backlight.push_back(predict_backlight(cmd_t'(evt_ch.cmd),
				evt_ch.idle_ms, evt_ch.booking_active, evt_ch.now_us));
		end
		if (res_acc) begin
			if (pending_backlight.size() == 0) begin
				$error("result word arrived with no event waiting for it");
				fail_count++;
			end else begin
				want = pending_backlight.pop_front();
				check_field("drive_valid", want.drive_valid, res_ch.drive_valid);
				check_field("brightness", want.brightness, res_ch.brightness);
				check_field("sleeping", want.sleeping, res_ch.sleeping);
				check_field("fade_active", want.fade_active, res_ch.fade_active);
				words_checked++;
			end
		end
		if (evt_acc || res_acc || psel) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
	end

	initial begin : watchdog
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("Some tests failed");
		$finish;
	end

	// The receiver stalls at random at the current idle rate.
	always @(negedge clk) begin
		res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Send one event word, with a random gap before it; returns at the
	// falling edge after the word is taken.
	task automatic send_event(input cmd_t c, input logic [INACT_W-1:0] inact,
			input logic booking, input logic [TIME_W-1:0] now);
		if ($urandom_range(99) < send_idle_pct) begin
			evt_ch.valid <= 1'b0;
			do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		evt_ch.valid <= 1'b1;
		evt_ch.cmd <= c;
		evt_ch.idle_ms <= inact;
		evt_ch.booking_active <= booking;
		evt_ch.now_us <= now;
		do @(posedge clk); while (!evt_ch.ready);
		events_sent++;
		@(negedge clk);
	endtask

	// Hold off new events until every expected result word is back.
	task automatic wait_drained();
		evt_ch.valid <= 1'b0;
		while (pending_backlight.size() != 0) begin
			@(negedge clk);
		end
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic apb_access(input logic wr, input logic [1:0] idx,
			input logic [PDATA_W-1:0] wdata, output logic [PDATA_W-1:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= PADDR_W'({idx, 2'b00});
		pwdata <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	// Write a register, update the predictor's copy and read it back.
	task automatic set_register(input logic [1:0] idx, input logic [PDATA_W-1:0] data);
		logic [PDATA_W-1:0] rdata;
		logic [TIMEOUT_W-1:0] v;
		apb_access(1'b1, idx, data, rdata);
		v = data[TIMEOUT_W-1:0];
		case (idx)
			REG_TIMEOUT: begin
				if (v != '0 && v < TIMEOUT_MIN) begin
					v = TIMEOUT_MIN;
				end
				if (v > TIMEOUT_MAX) begin
					v = TIMEOUT_MAX;
				end
				sleep_after_cfg = v;
			end
			REG_GRACE: begin
				grace_us_cfg = data[GRACE_W-1:0];
			end
			default: begin
				thresh_ms_cfg = data[THRESH_W-1:0];
			end
		endcase
		apb_access(1'b0, idx, '0, rdata);
		case (idx)
			REG_TIMEOUT: check_field("sleep_after_ms", sleep_after_cfg, rdata);
			REG_GRACE: check_field("wake_grace_us", grace_us_cfg, rdata);
			default: check_field("activity_threshold_ms", thresh_ms_cfg, rdata);
		endcase
	endtask

	task automatic test_register_defaults();
		logic [PDATA_W-1:0] rdata;
		apb_access(1'b0, REG_TIMEOUT, '0, rdata);
		check_field("sleep_after_ms", TIMEOUT_DEFAULT, rdata);
		apb_access(1'b0, REG_GRACE, '0, rdata);
		check_field("wake_grace_us", GRACE_DEFAULT, rdata);
		apb_access(1'b0, REG_THRESH, '0, rdata);
		check_field("activity_threshold_ms", THRESH_DEFAULT, rdata);
	endtask

	// Hand-picked events through sleep, grace, wake and the fade ramp.
	task automatic test_directed_events();
		logic [TIME_W-1:0] t0;
		t0 = TIME_W'(1000);
		send_event(CMD_CHECK, '0, 1'b0, '0);
		// A tick with no ramp running does nothing.
		send_event(CMD_TICK, '1, 1'b1, '1);
		send_event(CMD_WAKE, '0, 1'b0, '0);
		send_event(CMD_CHECK, INACT_W'(TIMEOUT_DEFAULT) - 1, 1'b0, t0);
		send_event(CMD_CHECK, INACT_W'(TIMEOUT_DEFAULT), 1'b0, t0);
		send_event(CMD_SLEEP, '0, 1'b0, TIME_W'(5000));
		// Activity exactly at the grace limit is still too early.
		send_event(CMD_CHECK, '0, 1'b0, t0 + TIME_W'(GRACE_DEFAULT));
		send_event(CMD_CHECK, INACT_W'(THRESH_DEFAULT) + 1, 1'b0, t0 + TIME_W'(GRACE_DEFAULT) + 1);
		send_event(CMD_CHECK, INACT_W'(THRESH_DEFAULT), 1'b0, t0 + TIME_W'(GRACE_DEFAULT) + 1);
		send_event(CMD_TICK, '0, 1'b0, '0);
		send_event(CMD_TICK, '0, 1'b0, '0);
		// Sleeping in the middle of a ramp leaves the ramp running.
		send_event(CMD_SLEEP, '0, 1'b0, TIME_W'(5000000));
		send_event(CMD_TICK, '0, 1'b0, '0);
		send_event(CMD_CHECK, '0, 1'b0, TIME_W'(4000000));
		send_event(CMD_CHECK, '1, 1'b1, TIME_W'(4000000));
		send_event(CMD_WAKE, '0, 1'b0, '0);
		repeat (7) send_event(CMD_TICK, '0, 1'b0, '0);
		send_event(CMD_CHECK, '1, 1'b1, '1);
		send_event(CMD_SLEEP, '1, 1'b1, '1);
		send_event(CMD_CHECK, '0, 1'b0, '1);
	endtask

	// Timeout writes clamp to the legal span; zero disables the check.
	task automatic test_timeout_clamp();
		logic [PDATA_W-1:0] values[8];
		int i;
		values = '{32'd0, 32'd1, 32'd59999, 32'd60000, 32'd43200000, 32'd43200001,
			32'hFFFF_FFFF, 32'hFC00_0000};
		for (i = 0; i < 8; i++) begin
			wait_drained();
			set_register(REG_TIMEOUT, values[i]);
			send_event(CMD_WAKE, '0, 1'b0, '0);
			send_event(CMD_CHECK, INACT_W'(TIMEOUT_MIN), 1'b0, TIME_W'(i));
			send_event(CMD_CHECK, INACT_W'(TIMEOUT_MAX), 1'b0, TIME_W'(i));
		end
	endtask

	// Random events over several register settings and idling patterns.
	task automatic test_random_traffic();
		int unsigned mode;
		int unsigned setting;
		int unsigned n;
		cmd_t c;
		logic [INACT_W-1:0] inact;
		logic [TIME_W-1:0] now;
		int unsigned roll;
		for (mode = 0; mode < 3; mode++) begin
			case (mode)
				0: begin
					send_idle_pct = 23;
					recv_idle_pct = 80;
				end
				1: begin
					send_idle_pct = 80;
					recv_idle_pct = 23;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			for (setting = 0; setting < 4; setting++) begin
				wait_drained();
				case (setting)
					0: begin
						set_register(REG_TIMEOUT, PDATA_W'(TIMEOUT_DEFAULT));
						set_register(REG_GRACE, PDATA_W'(GRACE_DEFAULT));
						set_register(REG_THRESH, PDATA_W'(THRESH_DEFAULT));
					end
					1: begin
						set_register(REG_TIMEOUT, PDATA_W'(TIMEOUT_MIN));
						set_register(REG_GRACE, '0);
						set_register(REG_THRESH, '0);
					end
					2: begin
						set_register(REG_TIMEOUT, PDATA_W'(TIMEOUT_MAX));
						set_register(REG_GRACE, 32'h03FF_FFFF);
						set_register(REG_THRESH, 32'h0000_FFFF);
					end
					default: begin
						set_register(REG_TIMEOUT, $urandom);
						set_register(REG_GRACE, $urandom_range(0, 60000000));
						set_register(REG_THRESH, $urandom);
					end
				endcase
				settings_used++;
				for (n = 0; n < WORDS_PER_SETTING; n++) begin
					if ($urandom_range(99) < 2) begin
						wait_drained();
					end
					roll = $urandom_range(99);
					if (roll < 45) begin
						c = CMD_CHECK;
					end else if (roll < 75) begin
						c = CMD_TICK;
					end else if (roll < 87) begin
						c = CMD_WAKE;
					end else begin
						c = CMD_SLEEP;
					end
					// Time mostly moves forward, sometimes jumps or steps back.
					roll = $urandom_range(99);
					if (roll < 3) begin
						clock_us = TIME_W'({$urandom, $urandom});
					end else if (roll < 7) begin
						clock_us = clock_us - TIME_W'($urandom_range(0, 2000000));
					end else begin
						clock_us = clock_us + TIME_W'($urandom_range(0, grace_us_cfg / 2 + 2000));
					end
					now = ($urandom_range(99) < 5) ? TIME_W'({$urandom, $urandom}) : clock_us;
					// Inactivity clusters around the threshold and the timeout.
					case ($urandom_range(5))
						0: inact = $urandom_range(0, thresh_ms_cfg);
						1: inact = INACT_W'(thresh_ms_cfg) + 1;
						2: inact = INACT_W'(sleep_after_cfg) - $urandom_range(0, 1);
						3: inact = INACT_W'(sleep_after_cfg) + $urandom_range(0, 100000);
						4: inact = $urandom;
						default: inact = $urandom_range(0, 1000);
					endcase
					send_event(c, inact, ($urandom_range(99) < 12), now);
				end
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		evt_ch.valid = 1'b0;
		evt_ch.cmd = CMD_CHECK;
		evt_ch.idle_ms = '0;
		evt_ch.booking_active = 1'b0;
		evt_ch.now_us = '0;
		res_ch.ready = 1'b0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_register_defaults();
		test_directed_events();
		test_timeout_clamp();
		test_random_traffic();
		wait_drained();

		$display("Sent %0d events and checked %0d result words over %0d register settings,",
			events_sent, words_checked, settings_used);
		$display("with sender and receiver stalls in three idling patterns.");
		if (fail_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

@@ files.f @@
+incdir+rtl
rtl/dsbf_pkg.sv
rtl/dsbf_evt_if.sv
rtl/dsbf_res_if.sv
rtl/dsbf_cfg.sv
rtl/dsbf_core.sv
rtl/display_sleep_backlight_fade_unit.sv
verif/tb.sv
